// ===== src/assert_macros.svh =====
// Assertion macros used by the evaluator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define AST_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== src/iame_pkg.sv =====
`default_nettype none

package iame_pkg;

    localparam int DATA_W = 32;
    localparam int CH_W   = 8;
    localparam int CNT_W  = $clog2(DATA_W);

    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_TIMES = 8'h2A;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        SIGN_PLUS   = 2'd0,
        SIGN_MINUS  = 2'd1,
        SIGN_TIMES  = 2'd2,
        SIGN_DIVIDE = 2'd3
    } sign_t;

    typedef enum logic [1:0] {
        S_IDLE   = 2'd0,
        S_SETTLE = 2'd1,
        S_DIV    = 2'd2,
        S_EMIT   = 2'd3
    } state_t;

    // Request from the sequencer to the divider.
    typedef struct packed {
        logic              start;
        logic [DATA_W-1:0] dividend;
        logic [DATA_W-1:0] divisor;
    } div_req_t;

    // Response from the divider to the sequencer.
    typedef struct packed {
        logic              busy;
        logic              done;
        logic [DATA_W-1:0] quotient;
    } div_rsp_t;

    // Operator that a settling character selects for the next number.
    function automatic sign_t sign_of_char(input logic [CH_W-1:0] c);
        sign_t s;
        if (c == CH_PLUS)
            s = SIGN_PLUS;
        else if (c == CH_MINUS)
            s = SIGN_MINUS;
        else if (c == CH_TIMES)
            s = SIGN_TIMES;
        else
            s = SIGN_DIVIDE;
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== src/infix_add_mul_evaluator.sv =====
// Infix expression evaluator for + - * and truncating division.
// The input stream carries one ASCII character per word on s_axis_tdata, with
// s_axis_tlast marking the final character of an expression. Digits, spaces
// and other characters are all accepted; the block never rejects a word.
// One result word leaves on the master side for each expression: the value
// (sum plus top term, wrapping at 32 bits) on m_axis_tdata and the sticky
// division-by-zero flag on m_axis_tuser, with m_axis_tlast always high.
// A digit or a space that is not last is taken and the block stays idle. An
// operator is first accepted and then settles the pending number on the shared
// arithmetic path. A settle under a division sign runs the bit-serial divider,
// which produces one quotient bit per cycle; input waits until it is done.
// After the last character the emit state loads the output register.
// An output register holds the result, so the block keeps taking characters
// while the receiver stalls; only a second result that finds the register
// still full waits in the emit state until m_axis_tready frees it.
// Reset (rst_n low, asynchronous) clears the running sum, the top term, the
// pending number and the error flag, sets the sign to plus and drops
// m_axis_tvalid. Each emit restores these values but raises m_axis_tvalid.
`default_nettype none

`include "assert_macros.svh"

module infix_add_mul_evaluator
    import iame_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [CH_W-1:0]   s_axis_tdata,  // [7:0] ch
    input  wire logic              s_axis_tlast,  // last
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [DATA_W-1:0]      m_axis_tdata,  // [31:0] value
    output logic [0:0]             m_axis_tuser,  // [0] div_zero
    output logic                   m_axis_tlast
);

    state_t            state_reg, state_next;
    sign_t             sign_reg, sign_next;
    logic [DATA_W-1:0] sum_reg, sum_next;
    logic [DATA_W-1:0] top_reg, top_next;
    logic [DATA_W-1:0] pend_reg, pend_next;
    logic              err_reg, err_next;
    logic [CH_W-1:0]   ch_reg, ch_next;
    logic              last_reg, last_next;
    logic              neg_reg, neg_next;
    logic              ovalid_reg, ovalid_next;
    logic [DATA_W-1:0] oval_reg, oval_next;
    logic              oerr_reg, oerr_next;

    logic              in_accept;
    logic              is_digit;
    logic [3:0]        digit;
    logic              settles;
    logic              finish;
    logic              emit;
    logic [DATA_W-1:0] quot_signed;
    div_req_t          div_req;
    div_rsp_t          div_rsp;

    // Bit-serial divider shared by every division settle.
    iame_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign is_digit      = (s_axis_tdata >= CH_ZERO) && (s_axis_tdata <= CH_NINE);
    assign digit         = 4'(s_axis_tdata - CH_ZERO);
    assign settles       = (!is_digit && (s_axis_tdata != CH_SPACE)) || s_axis_tlast;
    assign quot_signed   = neg_reg ? (DATA_W'(0) - div_rsp.quotient) : div_rsp.quotient;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            sign_reg   <= SIGN_PLUS;
            sum_reg    <= '0;
            top_reg    <= '0;
            pend_reg   <= '0;
            err_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sign_reg   <= sign_next;
            sum_reg    <= sum_next;
            top_reg    <= top_next;
            pend_reg   <= pend_next;
            err_reg    <= err_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ch_reg   <= ch_next;
        last_reg <= last_next;
        neg_reg  <= neg_next;
        oval_reg <= oval_next;
        oerr_reg <= oerr_next;
    end

    always_comb
    begin
        state_next  = state_reg;
        sign_next   = sign_reg;
        sum_next    = sum_reg;
        top_next    = top_reg;
        pend_next   = pend_reg;
        err_next    = err_reg;
        ch_next     = ch_reg;
        last_next   = last_reg;
        neg_next    = neg_reg;
        oval_next   = oval_reg;
        oerr_next   = oerr_reg;
        ovalid_next = ovalid_reg;
        finish      = 1'b0;
        emit        = 1'b0;
        div_req     = '0;

        if (ovalid_reg && m_axis_tready)
            ovalid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    ch_next   = s_axis_tdata;
                    last_next = s_axis_tlast;
                    // Times ten as two shifts and an add.
                    if (is_digit)
                        pend_next = (pend_reg << 3) + (pend_reg << 1) + DATA_W'(digit);
                    if (settles)
                        state_next = S_SETTLE;
                end
            end
            S_SETTLE:
            begin
                unique case (sign_reg)
                    SIGN_PLUS:
                    begin
                        sum_next = sum_reg + top_reg;
                        top_next = pend_reg;
                        finish   = 1'b1;
                    end
                    SIGN_MINUS:
                    begin
                        sum_next = sum_reg + top_reg;
                        top_next = DATA_W'(0) - pend_reg;
                        finish   = 1'b1;
                    end
                    SIGN_TIMES:
                    begin
                        top_next = DATA_W'(top_reg * pend_reg);
                        finish   = 1'b1;
                    end
                    SIGN_DIVIDE:
                    begin
                        if (pend_reg == '0)
                        begin
                            // Division by zero leaves the term as it is.
                            err_next = 1'b1;
                            finish   = 1'b1;
                        end
                        else
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = top_reg[DATA_W-1] ?
                                               (DATA_W'(0) - top_reg) : top_reg;
                            div_req.divisor  = pend_reg[DATA_W-1] ?
                                               (DATA_W'(0) - pend_reg) : pend_reg;
                            neg_next   = top_reg[DATA_W-1] ^ pend_reg[DATA_W-1];
                            state_next = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    top_next = quot_signed;
                    finish   = 1'b1;
                end
            end
            S_EMIT:
            begin
                if (!ovalid_reg || m_axis_tready)
                begin
                    emit        = 1'b1;
                    ovalid_next = 1'b1;
                    oval_next   = sum_reg + top_reg;
                    oerr_next   = err_reg;
                    sum_next    = '0;
                    top_next    = '0;
                    pend_next   = '0;
                    err_next    = 1'b0;
                    sign_next   = SIGN_PLUS;
                    state_next  = S_IDLE;
                end
            end
        endcase

        // Common end of a settle: the character picks the next sign.
        if (finish)
        begin
            sign_next  = sign_of_char(ch_reg);
            pend_next  = '0;
            state_next = last_reg ? S_EMIT : S_IDLE;
        end
    end

    assign m_axis_tvalid   = ovalid_reg;
    assign m_axis_tdata    = oval_reg;
    assign m_axis_tuser[0] = oerr_reg;
    assign m_axis_tlast    = 1'b1;

    // The divider only runs while the sequencer waits for it.
    `AST_IMPL(a_div_busy_in_div, clk, rst_n, div_rsp.busy, state_reg == S_DIV)
    `AST_IMPL(a_div_done_in_div, clk, rst_n, div_rsp.done, state_reg == S_DIV)
    // A digit or space that is not last never leaves the idle state.
    `AST_NEXT(a_plain_char_idle, clk, rst_n, in_accept && !settles, state_reg == S_IDLE)
    // Emitting a result returns the evaluation state to its reset values.
    `AST_NEXT(a_emit_clears, clk, rst_n, emit,
              m_axis_tvalid && (sum_reg == '0) && (top_reg == '0) && !err_reg)

endmodule

`default_nettype wire

// ===== src/iame_div.sv =====
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module iame_div
    import iame_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] dvs_reg, dvs_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        shifted   = {rem_reg, quo_reg[DATA_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // A remainder that stays below the divisor fits back in DATA_W bits.
            if (!diff[DATA_W])
            begin
                rem_next = diff[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DATA_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

`default_nettype wire

// ===== tb/iame_expr_checker.sv =====
`timescale 1ns / 1ps

module iame_expr_checker
    import iame_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    input  logic [CH_W-1:0]   s_axis_tdata,   // [7:0] ch
    input  logic              s_axis_tlast,   // last
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    input  logic [DATA_W-1:0] m_axis_tdata,   // [31:0] value
    input  logic [0:0]        m_axis_tuser,   // [0] div_zero
    input  logic              m_axis_tlast,
    output int                mismatch_count,
    output int                results_outstanding
);

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              div_zero;
    } expr_result_t;

    expr_result_t expected_results[$];

    logic [DATA_W-1:0] sum_acc;
    logic [DATA_W-1:0] term_acc;
    logic [DATA_W-1:0] number_acc;
    sign_t             sign_acc;
    logic              error_acc;
    int                errors_seen = 0;

    function automatic logic [DATA_W-1:0] divide_toward_zero(
        input logic [DATA_W-1:0] num,
        input logic [DATA_W-1:0] den
    );
        logic [DATA_W-1:0] mag_num;
        logic [DATA_W-1:0] mag_den;
        logic [DATA_W-1:0] quot;
        mag_num = num[DATA_W-1] ? ('0 - num) : num;
        mag_den = den[DATA_W-1] ? ('0 - den) : den;
        quot    = mag_num / mag_den;
        return (num[DATA_W-1] != den[DATA_W-1]) ? ('0 - quot) : quot;
    endfunction

    task automatic clear_expression();
        sum_acc    = '0;
        term_acc   = '0;
        number_acc = '0;
        sign_acc   = SIGN_PLUS;
        error_acc  = 1'b0;
    endtask

    // Folds the number being built into the term under the sign seen before it.
    task automatic settle_number();
        case (sign_acc)
            SIGN_PLUS:
            begin
                sum_acc  = sum_acc + term_acc;
                term_acc = number_acc;
            end
            SIGN_MINUS:
            begin
                sum_acc  = sum_acc + term_acc;
                term_acc = '0 - number_acc;
            end
            SIGN_TIMES:
            begin
                term_acc = term_acc * number_acc;
            end
            default:
            begin
                if (number_acc == '0)
                    error_acc = 1'b1;
                else
                    term_acc = divide_toward_zero(term_acc, number_acc);
            end
        endcase
    endtask

    task automatic absorb_char(input logic [CH_W-1:0] c, input logic is_last);
        logic         is_digit;
        expr_result_t res;
        is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
        if (is_digit)
            number_acc = number_acc * 32'd10 + {{(DATA_W-CH_W){1'b0}}, c - CH_ZERO};
        if ((!is_digit && c != CH_SPACE) || is_last)
        begin
            settle_number();
            case (c)
                CH_PLUS:  sign_acc = SIGN_PLUS;
                CH_MINUS: sign_acc = SIGN_MINUS;
                CH_TIMES: sign_acc = SIGN_TIMES;
                default:  sign_acc = SIGN_DIVIDE;
            endcase
            number_acc = '0;
        end
        if (is_last)
        begin
            res.value        = sum_acc + term_acc;
            res.div_zero     = error_acc;
            expected_results = {expected_results, res};
            clear_expression();
        end
    endtask

    task automatic report_mismatch(
        input string             what,
        input logic [DATA_W-1:0] got,
        input logic [DATA_W-1:0] want
    );
        $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        errors_seen++;
    endtask

    task automatic check_result();
        expr_result_t want;
        if (expected_results.size() == 0)
        begin
            report_mismatch("result word with no expression pending", m_axis_tdata, '0);
        end
        else
        begin
            want = expected_results.pop_front();
            if (m_axis_tdata !== want.value)
                report_mismatch("value", m_axis_tdata, want.value);
            if (m_axis_tuser[0] !== want.div_zero)
                report_mismatch("div_zero", DATA_W'(m_axis_tuser), DATA_W'(want.div_zero));
            if (m_axis_tlast !== 1'b1)
                report_mismatch("tlast", DATA_W'(m_axis_tlast), DATA_W'(1));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_expression();
            expected_results.delete();
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
                check_result();
            if (s_axis_tvalid && s_axis_tready)
                absorb_char(s_axis_tdata, s_axis_tlast);
        end
        mismatch_count      <= errors_seen;
        results_outstanding <= expected_results.size();
    end

endmodule

// ===== tb/infix_add_mul_evaluator_tb.sv =====
`timescale 1ns / 1ps

// Top of the evaluator testbench. It makes the character stream and the
// receiver's back-pressure, and gives the verdict. All prediction and
// comparison happens in the checker instance, which watches both channels.
module infix_add_mul_evaluator_tb;
    import iame_pkg::*;

    // Number of characters after which the random stream stops.
    localparam int ITEM_TARGET  = 900;
    // The last characters are sent with neither side idling.
    localparam int QUIET_ITEMS  = 120;
    // Once this many characters have gone in, the receiver holds off for a
    // long stretch so that the output register fills and the input stalls.
    localparam int HOLD_AT_ITEM = 300;
    localparam int HOLD_CYCLES  = 600;
    // Extra wait after the last result has come out; it covers a division
    // settle, the block's deepest latency.
    localparam int DRAIN_CYCLES = 40;

    localparam logic [CH_W-1:0] CH_SLASH = 8'h2F;

    logic              clk;
    logic              rst_n;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [CH_W-1:0]   s_axis_tdata;   // [7:0] ch
    logic              s_axis_tlast;   // last
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [DATA_W-1:0] m_axis_tdata;   // [31:0] value
    logic [0:0]        m_axis_tuser;   // [0] div_zero
    logic              m_axis_tlast;

    int mismatch_count;
    int results_outstanding;

    // Characters of the expression being built, sent as one run.
    logic [CH_W-1:0] expr_buf[$];
    int              items_sent  = 0;
    logic            hold_req    = 1'b0;
    logic            hold_done   = 1'b0;
    logic            quiet_phase = 1'b0;

    infix_add_mul_evaluator i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    iame_expr_checker i_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .s_axis_tvalid       (s_axis_tvalid),
        .s_axis_tready       (s_axis_tready),
        .s_axis_tdata        (s_axis_tdata),
        .s_axis_tlast        (s_axis_tlast),
        .m_axis_tvalid       (m_axis_tvalid),
        .m_axis_tready       (m_axis_tready),
        .m_axis_tdata        (m_axis_tdata),
        .m_axis_tuser        (m_axis_tuser),
        .m_axis_tlast        (m_axis_tlast),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // The limit lies well beyond the slowest correct run; a run that reaches
    // it is declared hung.
    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Offers one word and waits until the block has taken it. Before the
    // word, the sender sometimes idles for a short burst, except near the end.
    task automatic offer_char(input logic [CH_W-1:0] c, input logic is_last);
        if (!quiet_phase && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= is_last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        items_sent++;
        if (items_sent >= HOLD_AT_ITEM)
            hold_req = 1'b1;
        if (items_sent >= ITEM_TARGET - QUIET_ITEMS)
            quiet_phase = 1'b1;
    endtask

    // Sends the buffered expression with tlast on its final character.
    task automatic flush_expression();
        foreach (expr_buf[i])
            offer_char(expr_buf[i], i == expr_buf.size() - 1);
        expr_buf.delete();
    endtask

    // Adds one character at the end of the expression being built.
    task automatic append_char(input logic [CH_W-1:0] c);
        expr_buf = {expr_buf, c};
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            append_char(s[i]);
    endtask

    task automatic push_number(input longint unsigned v);
        push_text($sformatf("%0d", v));
    endtask

    // Numbers come mostly small, with zero often enough to hit division by
    // zero, plus values at the 32-bit edges and digit strings long enough
    // to wrap while they are built.
    task automatic push_operand();
        int pick;
        int n;
        pick = $urandom_range(0, 19);
        if (pick < 2)
        begin
            append_char(CH_ZERO);
        end
        else if (pick == 2)
        begin
            case ($urandom_range(0, 4))
                0: push_number(64'd1);
                1: push_number(64'd2147483647);
                2: push_number(64'd2147483648);
                3: push_number(64'd4294967295);
                default: push_number(64'd65536);
            endcase
        end
        else if (pick == 3)
        begin
            push_number(longint'($urandom()));
        end
        else if (pick == 4)
        begin
            n = $urandom_range(11, 13);
            repeat (n) append_char(CH_ZERO + CH_W'($urandom_range(0, 9)));
        end
        else if (pick < 10)
        begin
            push_number(longint'($urandom_range(0, 9)));
        end
        else
        begin
            push_number(longint'($urandom_range(0, 999)));
        end
    endtask

    task automatic push_operator();
        int pick;
        if ($urandom_range(0, 3) == 0)
            append_char(CH_SPACE);
        pick = $urandom_range(0, 9);
        if (pick < 3)
            append_char(CH_PLUS);
        else if (pick < 5)
            append_char(CH_MINUS);
        else if (pick < 7)
            append_char(CH_TIMES);
        else if (pick < 9)
            append_char(CH_SLASH);
        else
            append_char(CH_W'($urandom_range(0, 255)));
        if ($urandom_range(0, 3) == 0)
            append_char(CH_SPACE);
    endtask

    // Most expressions are well formed with random content. Some are pure
    // noise, and some well-formed ones get stray bytes or a dangling end.
    task automatic build_random_expression();
        int  pick;
        int  terms;
        int  len;
        bit  broken;
        pick = $urandom_range(0, 99);
        if (pick < 12)
        begin
            len = $urandom_range(1, 8);
            repeat (len) append_char(CH_W'($urandom_range(0, 255)));
        end
        else if (pick < 15)
        begin
            // The most negative value divided by minus one wraps to itself.
            push_text("-2147483648/4294967295");
        end
        else
        begin
            broken = (pick < 25);
            case ($urandom_range(0, 7))
                0: append_char(CH_SPACE);
                1: append_char(CH_MINUS);
                2: append_char(CH_TIMES);
                default: ;
            endcase
            terms = $urandom_range(1, 5);
            for (int t = 0; t < terms; t++)
            begin
                if (t != 0)
                    push_operator();
                if (broken && $urandom_range(0, 2) == 0)
                    append_char(CH_W'($urandom_range(0, 255)));
                push_operand();
            end
            case ($urandom_range(0, 9))
                0: append_char(CH_SPACE);
                1: push_operator();
                default: ;
            endcase
        end
    endtask

    // Receiver: random ready bursts, one long hold-off once requested, and
    // steady readiness during the final stretch.
    initial
    begin
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                hold_done = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (quiet_phase)
            begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(posedge clk);
            end
        end
    end

    // Sender and verdict.
    initial
    begin
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Division by zero keeps the term and raises the flag.
        push_text("7/0");
        flush_expression();
        // Times before any term acts on a zero term.
        push_text("*5");
        flush_expression();
        // An unknown character divides; a last space still settles the number.
        push_text("9x2 ");
        flush_expression();
        // Leading minus, and a plus that is itself the last character.
        push_text("-3+");
        flush_expression();
        // A number at the top of the unsigned range and a wrapping product.
        push_text("4294967295*3");
        flush_expression();

        while (items_sent < ITEM_TARGET)
        begin
            build_random_expression();
            flush_expression();
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        // Let the checker see the last word before looking at its backlog.
        @(posedge clk);
        while (results_outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && results_outstanding == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
